// ===== hdl/sece_pkg.sv =====
package sece_pkg;

  // datapath word: positions are only needed modulo 2**11
  localparam int unsigned DP_W = 11;
  localparam int unsigned TILE_STEP_DEF = 16;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned XPOS_W   = 10;
  localparam int unsigned YPOS_W   = 11;
  localparam int unsigned CHAIN_W  = 3;
  localparam int unsigned XOFF_W   = 3;

  // configuration register indexes
  localparam logic CFG_SCREEN_FLIP = 1'b0;
  localparam logic CFG_X_OFFSET    = 1'b1;

  // attribute byte bits
  localparam int unsigned ATTR_EN     = 0;
  localparam int unsigned ATTR_Y8     = 1;
  localparam int unsigned ATTR_X8     = 2;
  localparam int unsigned ATTR_FLIPY  = 3;
  localparam int unsigned ATTR_FLIPX  = 4;
  localparam int unsigned ATTR_CHAIN  = 5;

  // position constants
  localparam logic [DP_W-1:0] X_WRAP_LIMIT = DP_W'(496);
  localparam logic [DP_W-1:0] X_WRAP_SPAN  = DP_W'(512);
  localparam logic [DP_W-1:0] X_MIRROR     = DP_W'(304);
  localparam logic [DP_W-1:0] Y_BASE       = DP_W'(256);
  localparam logic [DP_W-1:0] Y_BIAS       = DP_W'(16);
  localparam logic [DP_W-1:0] Y_MIRROR     = DP_W'(240);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XWRAP,
    ST_XOFF,
    ST_XFLIP,
    ST_YINV,
    ST_YBIAS,
    ST_YFLIP,
    ST_YOFF,
    ST_ADJ,
    ST_EMIT
  } st_e;

  typedef enum logic [3:0] {
    OP_XWRAP,
    OP_XOFF,
    OP_XFLIP,
    OP_YINV,
    OP_YBIAS,
    OP_YFLIP,
    OP_YOFF,
    OP_YADJ,
    OP_YSTEP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic we;
    logic emit;
    logic last;
  } ctl_t;

endpackage

// ===== hdl/sece_alu.sv =====
module sece_alu (
  input  logic [sece_pkg::DP_W-1:0] a_i,
  input  logic [sece_pkg::DP_W-1:0] b_i,
  input  logic                      sub_i,
  output logic [sece_pkg::DP_W-1:0] sum_o
);
  import sece_pkg::*;

  logic [DP_W-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_eff + DP_W'(sub_i);

endmodule

// ===== hdl/sece_ctrl.sv =====
module sece_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          en_i,
  input  logic [sece_pkg::CHAIN_W-1:0]  n1_i,
  input  logic                          fy_raw_i,
  input  logic                          flip_i,
  input  logic                          slot_free_i,
  output logic                          ready_o,
  output sece_pkg::ctl_t                ctl_o
);
  import sece_pkg::*;

  st_e                state_q, state_d;
  logic [CHAIN_W-1:0] n1_q, n1_d;
  logic [CHAIN_W-1:0] cnt_q, cnt_d;
  logic [CHAIN_W-1:0] k_q, k_d;
  logic               fy_raw_q, fy_raw_d;
  logic               last_tile;

  assign last_tile = (k_q == n1_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (fire_i && en_i) state_d = ST_XWRAP;
      ST_XWRAP: state_d = ST_XOFF;
      ST_XOFF:  state_d = ST_XFLIP;
      ST_XFLIP: state_d = ST_YINV;
      ST_YINV:  state_d = ST_YBIAS;
      ST_YBIAS: state_d = ST_YFLIP;
      ST_YFLIP: state_d = ST_YOFF;
      ST_YOFF: begin
        // chain laid out from its far end: walk the start back first
        if (fy_raw_q && (n1_q != '0)) state_d = ST_ADJ;
        else state_d = ST_EMIT;
      end
      ST_ADJ:   if (cnt_q == CHAIN_W'(1)) state_d = ST_EMIT;
      ST_EMIT:  if (slot_free_i && last_tile) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n1_d     = n1_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    fy_raw_d = fy_raw_q;
    if (state_q == ST_IDLE && fire_i) begin
      n1_d     = n1_i;
      cnt_d    = n1_i;
      k_d      = '0;
      fy_raw_d = fy_raw_i;
    end
    if (state_q == ST_ADJ) cnt_d = cnt_q - CHAIN_W'(1);
    if (state_q == ST_EMIT && slot_free_i) k_d = k_q + CHAIN_W'(1);
  end

  always_comb begin
    ctl_o.op   = OP_XWRAP;
    ctl_o.we   = 1'b0;
    ctl_o.emit = 1'b0;
    ctl_o.last = last_tile;
    unique case (state_q)
      ST_IDLE:  ;
      ST_XWRAP: begin ctl_o.op = OP_XWRAP; ctl_o.we = 1'b1;   end
      ST_XOFF:  begin ctl_o.op = OP_XOFF;  ctl_o.we = 1'b1;   end
      ST_XFLIP: begin ctl_o.op = OP_XFLIP; ctl_o.we = flip_i; end
      ST_YINV:  begin ctl_o.op = OP_YINV;  ctl_o.we = 1'b1;   end
      ST_YBIAS: begin ctl_o.op = OP_YBIAS; ctl_o.we = 1'b1;   end
      ST_YFLIP: begin ctl_o.op = OP_YFLIP; ctl_o.we = flip_i; end
      ST_YOFF:  begin ctl_o.op = OP_YOFF;  ctl_o.we = flip_i; end
      ST_ADJ:   begin ctl_o.op = OP_YADJ;  ctl_o.we = 1'b1;   end
      ST_EMIT: begin
        ctl_o.op   = OP_YSTEP;
        ctl_o.we   = slot_free_i;
        ctl_o.emit = slot_free_i;
      end
      default: ;
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n1_q     <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      fy_raw_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      n1_q     <= n1_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      fy_raw_q <= fy_raw_d;
    end
  end

endmodule

// ===== hdl/sprite_entry_chain_expander_unit.sv =====
// Expands one sprite-table entry into one tile draw command per chained tile
// (1 to 8, in chain order, tlast on the final one); a disabled entry is taken
// and gives nothing. All position arithmetic runs through one shared 11-bit
// add/subtract unit under a small sequencer: an enabled entry is accepted and
// passes the X wrap, offset and flip and the Y invert, bias, flip and offset
// steps; if its flip Y bit is set the chain start is stepped back one tile a
// cycle, once per tile after the first; then one command per cycle is emitted
// while the output is not stalled. No entry is taken until the last command
// of the previous one is in the output register.
module sprite_entry_chain_expander_unit #(
  parameter int unsigned TileStep = sece_pkg::TILE_STEP_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [sece_pkg::XOFF_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // y_low, attr_byte, code_low, code_high, colour_in, x_low, zero pad
  input  logic [sece_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tile_code, colour_out, flip_x, flip_y, x_pos, y_pos, zero pad
  output logic [sece_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);
  import sece_pkg::*;

  localparam logic [DP_W-1:0] Step = DP_W'(TileStep);

  logic                flip_q, flip_d;
  logic [XOFF_W-1:0]   xoff_q, xoff_d;

  logic [7:0]          y_low, attr, x_low;
  logic [CODE_W-1:0]   code_in;
  logic [COLOUR_W-1:0] colour_in;
  logic [8:0]          x9, y9;
  logic                fire, slot_free;

  logic [DP_W-1:0]     rx_q, rx_d, ry_q, ry_d;
  logic                wrap_q, wrap_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic                fx_q, fx_d, fy_q, fy_d;

  logic [DP_W-1:0]     alu_a, alu_b, alu_sum;
  logic                alu_sub;
  ctl_t                ctl;

  logic                m_valid_q, m_valid_d;
  logic                o_last_q, o_last_d;
  logic [CODE_W-1:0]   o_code_q, o_code_d;
  logic [COLOUR_W-1:0] o_colour_q, o_colour_d;
  logic                o_fx_q, o_fx_d, o_fy_q, o_fy_d;
  logic [XPOS_W-1:0]   o_x_q, o_x_d;
  logic [YPOS_W-1:0]   o_y_q, o_y_d;

  assign y_low     = s_axis_tdata_i[7:0];
  assign attr      = s_axis_tdata_i[15:8];
  assign code_in   = s_axis_tdata_i[31:16];
  assign colour_in = s_axis_tdata_i[35:32];
  assign x_low     = s_axis_tdata_i[43:36];
  assign x9        = {attr[ATTR_X8], x_low};
  assign y9        = {attr[ATTR_Y8], y_low};

  assign fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !m_valid_q || m_axis_tready_i;

  // configuration
  always_comb begin
    flip_d = flip_q;
    xoff_d = xoff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_FLIP: flip_d = cfg_data_i[0];
        CFG_X_OFFSET:    xoff_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  sece_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .en_i        (attr[ATTR_EN]),
    .n1_i        (attr[ATTR_CHAIN +: CHAIN_W]),
    .fy_raw_i    (attr[ATTR_FLIPY]),
    .flip_i      (flip_q),
    .slot_free_i (slot_free),
    .ready_o     (s_axis_tready_o),
    .ctl_o       (ctl)
  );

  // operand selection for the shared adder
  always_comb begin
    alu_a   = rx_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctl.op)
      OP_XWRAP: begin alu_a = rx_q; alu_b = wrap_q ? X_WRAP_SPAN : '0; alu_sub = 1'b1; end
      OP_XOFF:  begin alu_a = rx_q; alu_b = DP_W'(xoff_q); alu_sub = 1'b0; end
      OP_XFLIP: begin alu_a = X_MIRROR; alu_b = rx_q; alu_sub = 1'b1; end
      OP_YINV:  begin alu_a = Y_BASE; alu_b = ry_q; alu_sub = 1'b1; end
      OP_YBIAS: begin alu_a = ry_q; alu_b = Y_BIAS; alu_sub = 1'b1; end
      OP_YFLIP: begin alu_a = Y_MIRROR; alu_b = ry_q; alu_sub = 1'b1; end
      OP_YOFF:  begin alu_a = ry_q; alu_b = DP_W'(xoff_q); alu_sub = 1'b1; end
      // step back against the layout direction
      OP_YADJ:  begin alu_a = ry_q; alu_b = Step; alu_sub = fy_q; end
      OP_YSTEP: begin alu_a = ry_q; alu_b = Step; alu_sub = !fy_q; end
      default: ;
    endcase
  end

  sece_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  always_comb begin
    rx_d     = rx_q;
    ry_d     = ry_q;
    wrap_d   = wrap_q;
    code_d   = code_q;
    colour_d = colour_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    if (fire) begin
      rx_d     = DP_W'(x9);
      ry_d     = DP_W'(y9);
      wrap_d   = (DP_W'(x9) > X_WRAP_LIMIT);
      code_d   = code_in;
      colour_d = colour_in;
      fx_d     = attr[ATTR_FLIPX] ^ flip_q;
      fy_d     = attr[ATTR_FLIPY] ^ flip_q;
    end else if (ctl.we) begin
      if (ctl.op == OP_XWRAP || ctl.op == OP_XOFF || ctl.op == OP_XFLIP) begin
        rx_d = alu_sum;
      end else if (ctl.op == OP_YINV) begin
        // inverted Y wraps modulo 512
        ry_d = DP_W'(alu_sum[8:0]);
      end else begin
        ry_d = alu_sum;
      end
    end
    if (ctl.emit) code_d = code_q + CODE_W'(1);
  end

  // output register
  always_comb begin
    m_valid_d  = m_valid_q;
    o_last_d   = o_last_q;
    o_code_d   = o_code_q;
    o_colour_d = o_colour_q;
    o_fx_d     = o_fx_q;
    o_fy_d     = o_fy_q;
    o_x_d      = o_x_q;
    o_y_d      = o_y_q;
    if (ctl.emit) begin
      m_valid_d  = 1'b1;
      o_last_d   = ctl.last;
      o_code_d   = code_q;
      o_colour_d = colour_q;
      o_fx_d     = fx_q;
      o_fy_d     = fy_q;
      o_x_d      = rx_q[XPOS_W-1:0];
      o_y_d      = ry_q[YPOS_W-1:0];
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q    <= 1'b0;
      xoff_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      flip_q    <= flip_d;
      xoff_q    <= xoff_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    wrap_q     <= wrap_d;
    code_q     <= code_d;
    colour_q   <= colour_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    o_last_q   <= o_last_d;
    o_code_q   <= o_code_d;
    o_colour_q <= o_colour_d;
    o_fx_q     <= o_fx_d;
    o_fy_q     <= o_fy_d;
    o_x_q      <= o_x_d;
    o_y_q      <= o_y_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = {
    (OUT_TDATA_W - YPOS_W - XPOS_W - 2 - COLOUR_W - CODE_W)'(0),
    o_y_q, o_x_q, o_fy_q, o_fx_q, o_colour_q, o_code_q
  };

`ifndef ASSERT_OFF
  // ready comes back only after the final command of a chain was loaded
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> $past(ctl.emit && ctl.last))
    else $error("ready returned before the chain was finished");

  // a disabled entry is dropped without leaving idle
  a_disabled_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !attr[ATTR_EN]) |=> s_axis_tready_o)
    else $error("disabled entry started a chain");

  // a new command is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |-> !ctl.emit)
    else $error("stalled command overwritten");
`endif

endmodule
